FILE: rtl/core/coa_pkg.sv
// Shared types and constants for the control ownership arbiter.
// No dependencies; imported by the queue cell and the top level.
`timescale 1ns / 1ps

package coa_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int ID_BITS_DEF     = 8;

  // Width of the reported waiting count field
  localparam int OUT_COUNT_BITS = 4;

  // Command codes
  typedef enum logic [1:0] {
    FUNC_REQUEST  = 2'd0,
    FUNC_GRAB     = 2'd1,
    FUNC_RELEASE  = 2'd2,
    FUNC_TRANSFER = 2'd3
  } func_t;

  // Status codes
  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_NOT_OWNER    = 2'd2,
    ST_NO_RECIPIENT = 2'd3
  } status_t;

  // Per-word control broadcast to every queue cell
  typedef struct packed {
    logic drop_en;    // remove first entry equal to match id
    logic append_en;  // write source id at the tail slot
  } cell_ctrl_t;

endpackage

FILE: rtl/core/coa_queue_cell.sv
// One slot of the waiting queue: holds an id, compares it, shifts down on removal.
// Depends on coa_pkg (cell_ctrl_t).
`timescale 1ns / 1ps

module coa_queue_cell #(
  parameter int IDX     = 0,
  parameter int ID_BITS = 8,
  parameter int CW      = 4
) (
  input  logic                clk,
  input  coa_pkg::cell_ctrl_t ctrl,
  input  logic [CW-1:0]       count,
  input  logic [ID_BITS-1:0]  match_id,
  input  logic [ID_BITS-1:0]  src_id,
  input  logic                found_in,
  output logic                found_out,
  input  logic                last_in,
  output logic                last_out,
  input  logic [ID_BITS-1:0]  next_data,
  output logic [ID_BITS-1:0]  data_out
);
  import coa_pkg::*;

  localparam logic [CW-1:0] IdxC   = CW'(IDX);
  localparam logic [CW-1:0] IdxP1C = CW'(IDX + 1);

  logic [ID_BITS-1:0] data_r;
  logic [ID_BITS-1:0] data_nxt;
  logic               occupied;
  logic               hit;

  assign occupied = (IdxC < count);
  assign hit      = occupied && (data_r == match_id);

  // First-match chain: set from the first matching slot onward
  assign found_out = found_in | hit;

  // Tail check: this slot is the last waiter and equals the source
  assign last_out = last_in | ((count == IdxP1C) && (data_r == src_id));

  assign data_out = data_r;

  // Shift down from the first match, or take the source at the tail slot
  always_comb begin
    data_nxt = data_r;
    if (ctrl.drop_en && found_out && occupied) begin
      data_nxt = next_data;
    end else if (ctrl.append_en && (count == IdxC)) begin
      data_nxt = src_id;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

FILE: rtl/core/control_ownership_arbiter.sv
// Control ownership arbiter: owner register plus a chain of queue cells.
// Depends on coa_pkg and coa_queue_cell.
//
//   channel | direction | handshake         | payload
//   in_     | input     | in_valid/in_stall | func, source_id, has_recipient, recipient_id
//   out_    | output    | out_valid/out_stall | status, owner_id, waiting_count, source_is_owner
//
// Each command is settled at once: the cell chain compares and shifts all slots together,
// and the result is registered.
// A new word is taken every cycle while the result register is free or being drained.
// in_stall is high while a result is held and out_stall is high.
// Synchronous reset clears owner, count and output valid; queue slots have no reset.
`timescale 1ns / 1ps

module control_ownership_arbiter #(
  parameter int QUEUE_DEPTH = coa_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = coa_pkg::ID_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_func,
  input  logic [ID_BITS-1:0]                 in_source_id,
  input  logic                               in_has_recipient,
  input  logic [ID_BITS-1:0]                 in_recipient_id,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_status,
  output logic [ID_BITS-1:0]                 out_owner_id,
  output logic [coa_pkg::OUT_COUNT_BITS-1:0] out_waiting_count,
  output logic                               out_source_is_owner
);
  import coa_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(QUEUE_DEPTH);

  logic               in_acc;
  logic [ID_BITS-1:0] owner_r, owner_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  status_t            status;
  cell_ctrl_t         ctrl;
  logic [ID_BITS-1:0] match_id;
  logic               drop_en, append_en;

  logic [ID_BITS-1:0] cell_data [QUEUE_DEPTH];
  logic               found_chain [QUEUE_DEPTH+1];
  logic               last_chain  [QUEUE_DEPTH+1];

  logic                      out_valid_r;
  status_t                   out_status_r;
  logic [ID_BITS-1:0]        out_owner_r;
  logic [OUT_COUNT_BITS-1:0] out_count_r;
  logic                      out_src_own_r;

  // Handshake
  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  // Queue cell chain
  assign found_chain[0] = 1'b0;
  assign last_chain[0]  = 1'b0;
  assign ctrl.drop_en   = drop_en & in_acc;
  assign ctrl.append_en = append_en & in_acc;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic [ID_BITS-1:0] nbr;
    if (g + 1 < QUEUE_DEPTH) begin : g_mid
      assign nbr = cell_data[g+1];
    end else begin : g_end
      assign nbr = cell_data[g];
    end
    coa_queue_cell #(
      .IDX     (g),
      .ID_BITS (ID_BITS),
      .CW      (CW)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (count_r),
      .match_id  (match_id),
      .src_id    (in_source_id),
      .found_in  (found_chain[g]),
      .found_out (found_chain[g+1]),
      .last_in   (last_chain[g]),
      .last_out  (last_chain[g+1]),
      .next_data (nbr),
      .data_out  (cell_data[g])
    );
  end

  // Command decode
  always_comb begin
    status    = ST_OK;
    owner_nxt = owner_r;
    drop_en   = 1'b0;
    append_en = 1'b0;
    match_id  = in_source_id;
    case (func_t'(in_func))
      FUNC_REQUEST: begin
        if (owner_r == '0) begin
          owner_nxt = in_source_id;
        end else if ((owner_r == in_source_id) && (count_r == '0)) begin
          // already in control, nobody waiting
        end else if (last_chain[QUEUE_DEPTH]) begin
          // already last in line
        end else if (count_r < DepthC) begin
          append_en = 1'b1;
        end else begin
          status = ST_FULL;
        end
      end
      FUNC_GRAB: begin
        owner_nxt = in_source_id;
        drop_en   = 1'b1;
      end
      FUNC_RELEASE: begin
        match_id = cell_data[0];
        if (owner_r != in_source_id) begin
          status = ST_NOT_OWNER;
        end else if (count_r != '0) begin
          owner_nxt = cell_data[0];
          drop_en   = 1'b1;
        end else begin
          owner_nxt = '0;
        end
      end
      FUNC_TRANSFER: begin
        match_id = in_recipient_id;
        if (owner_r != in_source_id) begin
          status = ST_NOT_OWNER;
        end else if (!in_has_recipient) begin
          status = ST_NO_RECIPIENT;
        end else begin
          owner_nxt = in_recipient_id;
          drop_en   = 1'b1;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  // Count update
  always_comb begin
    count_nxt = count_r;
    if (append_en) begin
      count_nxt = count_r + CW'(1);
    end else if (drop_en && found_chain[QUEUE_DEPTH]) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owner_r <= '0;
      count_r <= '0;
    end else if (in_acc) begin
      owner_r <= owner_nxt;
      count_r <= count_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_status_r  <= status;
      out_owner_r   <= owner_nxt;
      out_count_r   <= OUT_COUNT_BITS'(count_nxt);
      out_src_own_r <= (owner_nxt == in_source_id);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_owner_id        = out_owner_r;
  assign out_waiting_count   = out_count_r;
  assign out_source_is_owner = out_src_own_r;

endmodule
